@@ rtl/bpcd_pkg.sv @@
// Package for the button press classifier and dimmer.
// Holds field widths, phase and register index codes, and the duty lookup table.
// No dependencies.
package bpcd_pkg;

    // Field widths
    localparam int BRIGHT_W = 7;
    localparam int TICK_W   = 10;
    localparam int DUTY_W   = 10;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Duty scaling
    localparam int unsigned DUTY_FULL = 1023;
    localparam int unsigned DUTY_MAX  = 1023;
    localparam int unsigned PCT_MAX   = 100;

    // Counter ceiling
    localparam logic [TICK_W-1:0] COUNT_MAX = {TICK_W{1'b1}};

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CONFIRM = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HELD    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMIN_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMAX_TICKS = 2'd3;

    // Configuration reset values
    localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 7'd100;
    localparam logic [TICK_W-1:0]   LONG_RST   = 10'd300;
    localparam logic [TICK_W-1:0]   SMIN_RST   = 10'd10;
    localparam logic [TICK_W-1:0]   SMAX_RST   = 10'd200;

    // Press thresholds handed to the classifier
    typedef struct packed {
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] smin_ticks;
        logic [TICK_W-1:0] smax_ticks;
    } thresh_t;

    // Classifier flags for one sample
    typedef struct packed {
        logic short_press;
        logic long_press;
        logic running;
    } flags_t;

    // One result transaction
    typedef struct packed {
        logic              short_press;
        logic              long_press;
        logic              running;
        logic [DUTY_W-1:0] duty;
    } result_t;

    // Duty for each clamped brightness percent, built at elaboration
    typedef logic [PCT_MAX:0][DUTY_W-1:0] duty_lut_t;

    function automatic duty_lut_t build_duty_lut();
        duty_lut_t   lut;
        int unsigned q;
        for (int i = 0; i <= PCT_MAX; i++) begin
            q = (DUTY_FULL * i) / PCT_MAX;
            if (q > DUTY_MAX) begin
                lut[i] = DUTY_W'(DUTY_MAX);
            end else begin
                lut[i] = q[DUTY_W-1:0];
            end
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

@@ rtl/button_press_classifier_dimmer_top.sv @@
// An accepted sample's result is registered on the m_ side, parked in the skid stage first while one result waits.
// Throughput: one sample per cycle while the skid stage is empty; it keeps input open while one result waits.
// Reset (aresetn, synchronous, active low): phase idle, count 0, running, output empty,
// brightness 100, long 300, short window 10 to 200.
// Depends on bpcd_pkg, bpcd_fsm, bpcd_duty, bpcd_outq.
module button_press_classifier_dimmer_top
    import bpcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_button_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_short_press,
    output logic                  m_long_press,
    output logic                  m_running,
    output logic [DUTY_W-1:0]     m_duty
);

    logic [BRIGHT_W-1:0] brightness_reg;
    logic [TICK_W-1:0]   long_ticks_reg, smin_ticks_reg, smax_ticks_reg;
    thresh_t             thresh;
    flags_t              flags;
    logic [DUTY_W-1:0]   duty;
    logic                fire;
    result_t             res, m_res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHT_RST;
            long_ticks_reg <= LONG_RST;
            smin_ticks_reg <= SMIN_RST;
            smax_ticks_reg <= SMAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BRIGHTNESS: brightness_reg <= cfg_data[BRIGHT_W-1:0];
                CFG_LONG_TICKS: long_ticks_reg <= cfg_data[TICK_W-1:0];
                CFG_SMIN_TICKS: smin_ticks_reg <= cfg_data[TICK_W-1:0];
                CFG_SMAX_TICKS: smax_ticks_reg <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign thresh.long_ticks = long_ticks_reg;
    assign thresh.smin_ticks = smin_ticks_reg;
    assign thresh.smax_ticks = smax_ticks_reg;

    assign fire = s_valid && s_ready;

    bpcd_fsm u_fsm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .released (s_button_level),
        .thresh   (thresh),
        .flags    (flags)
    );

    bpcd_duty u_duty (
        .brightness (brightness_reg),
        .running    (flags.running),
        .duty       (duty)
    );

    // Assemble the result transaction
    assign res.short_press = flags.short_press;
    assign res.long_press  = flags.long_press;
    assign res.running     = flags.running;
    assign res.duty        = duty;

    bpcd_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .push_data (res),
        .ready     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_res)
    );

    assign m_short_press = m_res.short_press;
    assign m_long_press  = m_res.long_press;
    assign m_running     = m_res.running;
    assign m_duty        = m_res.duty;

endmodule

@@ rtl/bpcd_fsm.sv @@
// Press classifier: four-phase machine, hold counter and run/suspend mode.
// Depends on bpcd_pkg.
module bpcd_fsm
    import bpcd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  logic    released,
    input  thresh_t thresh,
    output flags_t  flags
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0]  hold_count_reg, hold_count_next;
    logic               run_mode_reg, run_mode_next;
    logic               sp, lp;

    // Work out the next phase, count and mode for this sample
    always_comb begin
        phase_next      = phase_reg;
        hold_count_next = hold_count_reg;
        run_mode_next   = run_mode_reg;
        sp              = 1'b0;
        lp              = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (!released) phase_next = PH_CONFIRM;
            end
            PH_CONFIRM: begin
                if (!released) begin
                    hold_count_next = '0;
                    phase_next      = PH_HELD;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HELD: begin
                if (hold_count_reg <= thresh.long_ticks && hold_count_reg != COUNT_MAX) begin
                    hold_count_next = hold_count_reg + 1'b1;
                end else begin
                    lp         = 1'b1;
                    phase_next = PH_RELEASE;
                end
                if (released) phase_next = PH_RELEASE;
            end
            PH_RELEASE: begin
                if (released) begin
                    if (hold_count_reg >= thresh.smin_ticks &&
                        hold_count_reg < thresh.smax_ticks) begin
                        sp            = 1'b1;
                        run_mode_next = ~run_mode_reg;
                    end
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Advance state on each accepted sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hold_count_reg <= '0;
            run_mode_reg   <= 1'b1;
        end else if (fire) begin
            phase_reg      <= phase_next;
            hold_count_reg <= hold_count_next;
            run_mode_reg   <= run_mode_next;
        end
    end

    assign flags.short_press = sp;
    assign flags.long_press  = lp;
    assign flags.running     = run_mode_next;

`ifndef SYNTHESIS
    a_sp_from_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && sp) |-> (phase_reg == PH_RELEASE && released))
        else $error("short press outside release wait");
    a_lp_to_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && lp) |=> (phase_reg == PH_RELEASE))
        else $error("long press did not move to release wait");
    a_sp_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && sp) |=> (run_mode_reg != $past(run_mode_reg)))
        else $error("short press did not toggle mode");
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(phase_reg) && $stable(hold_count_reg)))
        else $error("state moved without a transaction");
`endif

endmodule

@@ rtl/bpcd_duty.sv @@
// LED duty: clamp brightness to 100 percent and look up the scaled duty, or zero while suspended.
// Depends on bpcd_pkg (DUTY_LUT).
module bpcd_duty
    import bpcd_pkg::*;
(
    input  logic [BRIGHT_W-1:0] brightness,
    input  logic                running,
    output logic [DUTY_W-1:0]   duty
);

    logic [BRIGHT_W-1:0] pct;

    // Clamp, then drop to zero while suspended
    assign pct  = (brightness > BRIGHT_W'(PCT_MAX)) ? BRIGHT_W'(PCT_MAX) : brightness;
    assign duty = running ? DUTY_LUT[pct] : '0;

endmodule

@@ rtl/bpcd_outq.sv @@
// Result register with a skid stage, so a new transaction is taken while one waits.
// Depends on bpcd_pkg (result_t).
module bpcd_outq
    import bpcd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    pop;

    assign pop     = out_valid_reg && m_ready;
    assign ready   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Control: refill from the skid stage first, else take the new result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (!out_valid_reg || pop) out_valid_reg <= 1'b1;
            else skid_valid_reg <= 1'b1;
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) out_data_reg <= skid_data_reg;
        end else if (push) begin
            if (!out_valid_reg || pop) out_data_reg <= push_data;
            else skid_data_reg <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while result register empty");
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !pop) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid stage lost its transaction");
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && ready && out_valid_reg && !pop) |=> skid_valid_reg)
        else $error("stalled transaction not parked");
`endif

endmodule
